// ===== hw/rtl/hfq_pkg.sv =====
// ----------------------------------------------------------------------------
// hfq_pkg
// Shared types and constants for the heightfield height query block: field
// widths, operation and register codes, and the item passed from the front
// end to the back end through the queue.
// ----------------------------------------------------------------------------
package hfq_pkg;

	// Fixed field widths.
	localparam int unsigned CELL_W = 8;   // cells_across, cells_down
	localparam int unsigned IDX_W  = 16;  // vertex_index, store address
	localparam int unsigned H_W    = 24;  // heights
	localparam int unsigned POS_W  = 16;  // pos_x, pos_z

	localparam int H_MAX = 8388607;
	localparam int H_MIN = -8388608;

	// Parameter defaults.
	localparam int unsigned MAX_CELLS_DEF   = 255;
	localparam int unsigned FRAC_BITS_DEF   = 8;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// Fraction fields in the queue item are sized for the largest fraction width.
	localparam int unsigned FRAC_BITS_MAX = 12;
	localparam int unsigned FRAC_FIELD_W  = FRAC_BITS_MAX + 1;

	// Configuration port.
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} hfq_op_t;

	typedef enum logic [0:0] {
		REG_CELLS_ACROSS = 1'b0,
		REG_CELLS_DOWN   = 1'b1
	} hfq_reg_t;

	// One classified item: either a store write or a query with its cell and
	// in-cell fractions already worked out.
	typedef struct packed {
		logic                    is_query;
		logic                    in_range;
		logic [CELL_W-1:0]       cell_x;
		logic [CELL_W-1:0]       cell_y;
		logic [FRAC_FIELD_W-1:0] frac_x;
		logic [FRAC_FIELD_W-1:0] frac_y;
		logic [IDX_W-1:0]        wr_index;
		logic [H_W-1:0]          wr_height;
	} hfq_item_t;

endpackage

// ===== hw/rtl/hfq_front.sv =====
// ----------------------------------------------------------------------------
// hfq_front
// Classifies an incoming item. Queries get the grid range check, the cell
// coordinates and the in-cell fractions, with the far border clamped onto the
// last cell.
// ----------------------------------------------------------------------------
module hfq_front #(
	parameter int unsigned FRAC_BITS = hfq_pkg::FRAC_BITS_DEF
) (
	input  logic                              op,
	input  logic [hfq_pkg::IDX_W-1:0]         vertex_index,
	input  logic signed [hfq_pkg::H_W-1:0]    height_value,
	input  logic signed [hfq_pkg::POS_W-1:0]  pos_x,
	input  logic signed [hfq_pkg::POS_W-1:0]  pos_z,
	input  logic [hfq_pkg::CELL_W-1:0]        cells_across,
	input  logic [hfq_pkg::CELL_W-1:0]        cells_down,
	output hfq_pkg::hfq_item_t                item
);
	import hfq_pkg::*;

	localparam int unsigned GRID_W = CELL_W + FRAC_BITS;
	localparam int unsigned CW = ((GRID_W > POS_W) ? GRID_W : POS_W) + 2;
	localparam logic [FRAC_FIELD_W-1:0] FRAC_ONE = FRAC_FIELD_W'(1) << FRAC_BITS;

	logic signed [CW-1:0] px_e, pz_e, hx_e, hz_e, fx, fz;
	logic [CELL_W:0]      ix_raw, iy_raw;

	always_comb begin
		px_e = CW'(pos_x);
		pz_e = CW'(pos_z);
		hx_e = CW'({cells_across, {(FRAC_BITS-1){1'b0}}});
		hz_e = CW'({cells_down, {(FRAC_BITS-1){1'b0}}});
		fx = px_e + hx_e;
		fz = hz_e - pz_e;
		ix_raw = fx[FRAC_BITS +: CELL_W+1];
		iy_raw = fz[FRAC_BITS +: CELL_W+1];

		item = '0;
		item.is_query  = (op == OP_QUERY);
		item.in_range  = !((px_e < -hx_e) || (px_e > hx_e) ||
			(pz_e < -hz_e) || (pz_e > hz_e));
		item.wr_index  = vertex_index;
		item.wr_height = height_value;

		// A point on the far border belongs to the last cell at full fraction.
		if (ix_raw >= {1'b0, cells_across}) begin
			item.cell_x = cells_across - CELL_W'(1);
			item.frac_x = FRAC_ONE;
		end else begin
			item.cell_x = ix_raw[CELL_W-1:0];
			item.frac_x = FRAC_FIELD_W'(fx[FRAC_BITS-1:0]);
		end
		if (iy_raw >= {1'b0, cells_down}) begin
			item.cell_y = cells_down - CELL_W'(1);
			item.frac_y = FRAC_ONE;
		end else begin
			item.cell_y = iy_raw[CELL_W-1:0];
			item.frac_y = FRAC_FIELD_W'(fz[FRAC_BITS-1:0]);
		end
	end

endmodule

// ===== hw/rtl/hfq_queue.sv =====
// ----------------------------------------------------------------------------
// hfq_queue
// Small first-in first-out queue of classified items between the front end
// and the back end.
// ----------------------------------------------------------------------------
module hfq_queue #(
	parameter int unsigned DEPTH = hfq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  hfq_pkg::hfq_item_t push_item,
	input  logic               pop,
	output hfq_pkg::hfq_item_t head_item,
	output logic               empty,
	output logic               full
);
	import hfq_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	hfq_item_t        entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_ok, pop_ok;

	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign push_ok   = push && !full;
	assign pop_ok    = pop && !empty;
	assign head_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && !pop |=> !empty)
		else $error("queue empty after a push");
`endif

endmodule

// ===== hw/rtl/hfq_back.sv =====
// ----------------------------------------------------------------------------
// hfq_back
// Carries out queued items: vertex address, height store write or four-corner
// read, triangle selection, the two fraction products and the saturated sum.
// ----------------------------------------------------------------------------
module hfq_back #(
	parameter int unsigned FRAC_BITS = hfq_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hfq_pkg::hfq_item_t              head_item,
	input  logic                            head_valid,
	output logic                            pop,
	input  logic [hfq_pkg::CELL_W-1:0]      cells_across,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [hfq_pkg::H_W-1:0]  height_out,
	output logic                            in_range
);
	import hfq_pkg::*;

	localparam int unsigned FR_W = FRAC_BITS + 1;
	localparam int unsigned D_W  = H_W + 1;
	localparam int unsigned P_W  = FR_W + 1 + D_W;
	localparam int unsigned S_W  = P_W + 1;
	localparam int unsigned LT_W = 2*CELL_W + 1;
	localparam int unsigned STORE_DEPTH = 2**IDX_W;
	localparam logic signed [S_W-1:0] SAT_HI = S_W'(H_MAX);
	localparam logic signed [S_W-1:0] SAT_LO = S_W'(H_MIN);

	logic adv;
	logic [CELL_W:0] stride;
	logic [LT_W-1:0] lt_full;

	// Stage 1: vertex address.
	logic             valid_s1, query_s1, in_range_s1;
	logic [IDX_W-1:0] lt_s1, widx_s1;
	logic [H_W-1:0]   wdata_s1;
	logic [FR_W-1:0]  frx_s1, fry_s1;
	logic [IDX_W-1:0] a_tr, a_bl, a_br;
	logic             wr_en;

	// Stage 2: store read data.
	logic             valid_s2, in_range_s2;
	logic [FR_W-1:0]  frx_s2, fry_s2;
	logic [H_W-1:0]   tl_s2, tr_s2, bl_s2, br_s2;

	// Stage 3: triangle differences.
	logic                  valid_s3, in_range_s3;
	logic [FR_W-1:0]       frx_s3, fry_s3;
	logic signed [H_W-1:0] tl_s3;
	logic signed [D_W-1:0] d1_s3, d2_s3;
	logic signed [D_W-1:0] tl_e, tr_e, bl_e, br_e, d1, d2;
	logic                  upper_tri;

	// Stage 4: products.
	logic                  valid_s4, in_range_s4;
	logic signed [H_W-1:0] tl_s4;
	logic signed [P_W-1:0] p1_s4, p2_s4;

	// Output register.
	logic                  out_valid_q, in_range_q;
	logic signed [H_W-1:0] height_q;
	logic signed [S_W-1:0] sum;
	logic signed [H_W-1:0] height_sat;

	logic [H_W-1:0] mem_a [STORE_DEPTH];
	logic [H_W-1:0] mem_b [STORE_DEPTH];

	// The whole pipeline moves together unless a result waits on a stall.
	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && head_valid;

	assign stride  = (CELL_W+1)'(cells_across) + (CELL_W+1)'(1);
	assign lt_full = LT_W'(head_item.cell_y) * LT_W'(stride) + LT_W'(head_item.cell_x);

	assign a_tr  = lt_s1 + IDX_W'(1);
	assign a_bl  = lt_s1 + IDX_W'(stride);
	assign a_br  = a_bl + IDX_W'(1);
	assign wr_en = valid_s1 && !query_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= head_valid;
			valid_s2    <= valid_s1 && query_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			query_s1    <= head_item.is_query;
			in_range_s1 <= head_item.in_range;
			lt_s1       <= lt_full[IDX_W-1:0];
			widx_s1     <= head_item.wr_index;
			wdata_s1    <= head_item.wr_height;
			frx_s1      <= head_item.frac_x[FR_W-1:0];
			fry_s1      <= head_item.frac_y[FR_W-1:0];

			in_range_s2 <= in_range_s1;
			frx_s2      <= frx_s1;
			fry_s2      <= fry_s1;

			in_range_s3 <= in_range_s2;
			frx_s3      <= frx_s2;
			fry_s3      <= fry_s2;
			tl_s3       <= signed'(tl_s2);
			d1_s3       <= d1;
			d2_s3       <= d2;

			in_range_s4 <= in_range_s3;
			tl_s4       <= tl_s3;
			p1_s4       <= P_W'(signed'({1'b0, frx_s3})) * P_W'(d1_s3);
			p2_s4       <= P_W'(signed'({1'b0, fry_s3})) * P_W'(d2_s3);

			in_range_q  <= in_range_s4;
			height_q    <= in_range_s4 ? height_sat : '0;
		end
	end

	// Two copies of the store, each with two read ports, give the four corners.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (wr_en) begin
				mem_a[widx_s1] <= wdata_s1;
			end
			tl_s2 <= mem_a[lt_s1];
			tr_s2 <= mem_a[a_tr];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (wr_en) begin
				mem_b[widx_s1] <= wdata_s1;
			end
			bl_s2 <= mem_b[a_bl];
			br_s2 <= mem_b[a_br];
		end
	end

	always_comb begin
		tl_e = D_W'(signed'(tl_s2));
		tr_e = D_W'(signed'(tr_s2));
		bl_e = D_W'(signed'(bl_s2));
		br_e = D_W'(signed'(br_s2));
		upper_tri = (frx_s2 > fry_s2);
		if (upper_tri) begin
			d1 = tr_e - tl_e;
			d2 = br_e - tr_e;
		end else begin
			d1 = br_e - bl_e;
			d2 = bl_e - tl_e;
		end
	end

	always_comb begin
		sum = S_W'(tl_s4) + S_W'(p1_s4 >>> FRAC_BITS) + S_W'(p2_s4 >>> FRAC_BITS);
		if (sum > SAT_HI) begin
			height_sat = SAT_HI[H_W-1:0];
		end else if (sum < SAT_LO) begin
			height_sat = SAT_LO[H_W-1:0];
		end else begin
			height_sat = sum[H_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign height_out = height_q;
	assign in_range   = in_range_q;

`ifndef ASSERT_OFF
	a_off_grid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !in_range_q |-> height_q == '0)
		else $error("off-grid result with nonzero height");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 && !query_s1 |=> !valid_s2)
		else $error("store write moved on as a result");
`endif

endmodule

// ===== hw/rtl/heightfield_height_query.sv =====
// ----------------------------------------------------------------------------
// heightfield_height_query
// Terrain height lookup over a vertex grid centred on the origin, with a
// store write operation and a triangle-interpolated height query.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// --------  ---------  ---------------------  --------------------------------------
// input     in         in_valid / in_stall    op, vertex_index, height_value,
//                                             pos_x, pos_z
// output    out        out_valid / out_stall  height_out, in_range
// config    in         APB psel/penable/...   cells_across (0x0), cells_down (0x4)
//
// The block takes one transfer per cycle on the input while in_stall is low, and
// gives one result transfer per cycle for a stream of queries while out_stall is
// low; writes give no result. A query result passes through the queue, then the
// address, store read, triangle differences and products stages, with the sum
// landing in the output register.
// Reset clears the pipeline and the queue and sets both cell counts to one;
// the height store keeps no reset value and must be written before it is read.
// A stalled output freezes the back end while the front end keeps filling the
// queue; in_stall rises only when the queue is full.
//
// The four corners of a cell come from two copies of the store, each with two
// read ports, and every write goes to both copies. Configuration writes clamp
// a count of zero to one and a count above MAX_CELLS to MAX_CELLS; reads
// return the clamped value.
// ----------------------------------------------------------------------------
module heightfield_height_query #(
	parameter int unsigned MAX_CELLS   = hfq_pkg::MAX_CELLS_DEF,
	parameter int unsigned FRAC_BITS   = hfq_pkg::FRAC_BITS_DEF,
	parameter int unsigned QUEUE_DEPTH = hfq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              op,
	input  logic [hfq_pkg::IDX_W-1:0]         vertex_index,
	input  logic signed [hfq_pkg::H_W-1:0]    height_value,
	input  logic signed [hfq_pkg::POS_W-1:0]  pos_x,
	input  logic signed [hfq_pkg::POS_W-1:0]  pos_z,

	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [hfq_pkg::H_W-1:0]    height_out,
	output logic                              in_range,

	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [hfq_pkg::ADDR_W-1:0]        paddr,
	input  logic [hfq_pkg::DATA_W-1:0]        pwdata,
	output logic [hfq_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);
	import hfq_pkg::*;

	logic [CELL_W-1:0] cells_across_q, cells_down_q;
	logic              cfg_write;
	hfq_reg_t          reg_sel;

	hfq_item_t front_item, head_item;
	logic      q_empty, q_full, q_pop;

	// Zero acts as one cell, and anything above the supported size is cut down.
	function automatic logic [CELL_W-1:0] clamp_cells(input logic [CELL_W-1:0] v);
		logic [CELL_W-1:0] r;
		if (v == '0) begin
			r = CELL_W'(1);
		end else if (v > CELL_W'(MAX_CELLS)) begin
			r = CELL_W'(MAX_CELLS);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Registers sit on 32-bit word boundaries, so the register is chosen by
	// the word address bit.
	assign pready    = 1'b1;
	assign reg_sel   = hfq_reg_t'(paddr[2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_across_q <= CELL_W'(1);
			cells_down_q   <= CELL_W'(1);
		end else if (cfg_write) begin
			unique case (reg_sel)
				REG_CELLS_ACROSS: cells_across_q <= clamp_cells(pwdata[CELL_W-1:0]);
				REG_CELLS_DOWN:   cells_down_q   <= clamp_cells(pwdata[CELL_W-1:0]);
				default:          cells_down_q   <= cells_down_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_CELLS_ACROSS: prdata = DATA_W'(cells_across_q);
			REG_CELLS_DOWN:   prdata = DATA_W'(cells_down_q);
			default:          prdata = '0;
		endcase
	end

	// The front end classifies every input transfer straight into the queue.
	assign in_stall = q_full;

	hfq_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.op           (op),
		.vertex_index (vertex_index),
		.height_value (height_value),
		.pos_x        (pos_x),
		.pos_z        (pos_z),
		.cells_across (cells_across_q),
		.cells_down   (cells_down_q),
		.item         (front_item)
	);

	hfq_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid),
		.push_item (front_item),
		.pop       (q_pop),
		.head_item (head_item),
		.empty     (q_empty),
		.full      (q_full)
	);

	hfq_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_item    (head_item),
		.head_valid   (!q_empty),
		.pop          (q_pop),
		.cells_across (cells_across_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.height_out   (height_out),
		.in_range     (in_range)
	);

`ifndef ASSERT_OFF
	a_cells_legal: assert property (@(posedge clk) disable iff (!arst_n)
		cells_across_q != '0 && cells_across_q <= CELL_W'(MAX_CELLS) &&
		cells_down_q != '0 && cells_down_q <= CELL_W'(MAX_CELLS))
		else $error("cell count register outside its legal range");
`endif

endmodule
